// File: hdl/toroidal_life_automaton_core_defines.svh
// Assertion macros for the toroidal life automaton core.
`ifndef TOROIDAL_LIFE_AUTOMATON_CORE_DEFINES_SVH
`define TOROIDAL_LIFE_AUTOMATON_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TLA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/tla_pkg.sv
// Package with types and constants of the toroidal life automaton.
`timescale 1ns / 1ps
`default_nettype none
package tla_pkg;
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [3:0] CNT_MAX = 4'd8;
  localparam logic [3:0] CNT_TWO = 4'd2;
  localparam logic [3:0] CNT_THREE = 4'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT_RD,
    ST_PUT_WB,
    ST_NB_RD,
    ST_NB_WB,
    ST_COPY,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_GEN_END,
    ST_RESP
  } state_t;

  // Memory request from the sequencer to the cell store.
  typedef struct packed {
    logic rd;
    logic wr;
    logic snap_rd;
    logic snap_wr;
  } mem_ctl_t;
endpackage
`default_nettype wire

// File: hdl/toroidal_life_automaton_core.sv
// Top level of the toroidal life automaton: sequencer and cell store.
//  channel | direction | ports
//  in      | request   | in_valid/in_ready, in_operation, in_col, in_row, in_alive,
//          |           | in_generations
//  out     | result    | out_valid/out_ready, out_status, out_cell_alive,
//          |           | out_neighbour_count, out_generation
//  cfg     | write     | cfg_valid/cfg_ready, cfg_index, cfg_data
// After reset a clearing pass writes all MAX_WIDTH*MAX_HEIGHT cells, one a cycle;
// a geometry write starts the same pass. A read or a write in range raises its result
// after the cell is read and written back and, for a write that changes the cell,
// after the eight neighbour counts are updated. A generation copies every cell to the
// snapshot, then scans it, and updates the neighbours of each changed cell.
// The result waits in an output register until out_ready; the next request is
// taken after it is delivered.
`timescale 1ns / 1ps
`default_nettype none
`include "toroidal_life_automaton_core_defines.svh"
module toroidal_life_automaton_core
  import tla_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [5:0]  in_col,
  input  wire logic [5:0]  in_row,
  input  wire logic        in_alive,
  input  wire logic [15:0] in_generations,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic             out_cell_alive,
  output logic [3:0]       out_neighbour_count,
  output logic [31:0]      out_generation,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam int DW = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1) ?
                      $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int EW = DW > 7 ? DW : 7;

  state_t state_r, state_nxt;
  logic [6:0] gw_r, gh_r;
  logic [CW-1:0] ew, c_r, c_nxt, sc_r, sc_nxt, tc;
  logic [RW-1:0] eh, r_r, r_nxt, sr_r, sr_nxt, tr;
  logic [3:0] nb_r, nb_nxt;
  logic live_r, live_nxt, chg_r, chg_nxt;
  logic [15:0] gens_r, gens_nxt;
  logic [31:0] gen_r, gen_nxt;
  logic st_r, st_nxt, ca_r, ca_nxt;
  logic [3:0] nc_r, nc_nxt;
  logic outv_r, outv_nxt;
  logic [1:0] op_r, op_nxt;
  logic scan_r, scan_nxt;
  mem_ctl_t ctl;
  logic [AW-1:0] addr;
  logic [4:0] wdata, rdata, snap_rdata;
  logic [3:0] cnt;
  logic last_c, last_r, last_sc, last_sr;
  logic scan_done;

  // Effective dimensions clamped to 3..MAX.
  function automatic logic [EW-1:0] clampd(input logic [6:0] v, input int hi);
    logic [EW-1:0] x;
    x = EW'(v);
    if (x < EW'(3)) x = EW'(3);
    else if (x > EW'(hi)) x = EW'(hi);
    return x;
  endfunction

  logic [EW-1:0] ewf, ehf;
  assign ewf = clampd(gw_r, MAX_WIDTH);
  assign ehf = clampd(gh_r, MAX_HEIGHT);
  assign ew = CW'(ewf - EW'(1));
  assign eh = RW'(ehf - EW'(1));

  // Neighbour coordinate of the current update step.
  logic [3:0] k;
  assign k = (nb_r >= 4'd4) ? nb_r + 4'd1 : nb_r;
  always_comb begin
    case (k)
      4'd0, 4'd3, 4'd6: tc = (c_r == '0) ? ew : c_r - CW'(1);
      4'd2, 4'd5, 4'd8: tc = (c_r == ew) ? '0 : c_r + CW'(1);
      default: tc = c_r;
    endcase
    if (k <= 4'd2) tr = (r_r == '0) ? eh : r_r - RW'(1);
    else if (k >= 4'd6) tr = (r_r == eh) ? '0 : r_r + RW'(1);
    else tr = r_r;
  end

  assign last_c = (c_r == ew);
  assign last_r = (r_r == eh);
  assign last_sc = (sc_r == ew);
  assign last_sr = (sr_r == eh);
  assign cnt = rdata[4:1];

  // The scan position has wrapped back to the first cell once the last one is done.
  assign scan_done = (sc_r == '0) && (sr_r == '0);

  assign in_ready  = (state_r == ST_IDLE) && !outv_r && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE) && !outv_r;

  // Register updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      gw_r <= 7'd64;
      gh_r <= 7'd64;
      gen_r <= '0;
      outv_r <= 1'b0;
      c_r <= '0;
      r_r <= '0;
    end else begin
      state_r <= state_nxt;
      gen_r <= gen_nxt;
      outv_r <= outv_nxt;
      c_r <= c_nxt;
      r_r <= r_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) gw_r <= cfg_data;
        else gh_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    sc_r <= sc_nxt;
    sr_r <= sr_nxt;
    nb_r <= nb_nxt;
    live_r <= live_nxt;
    chg_r <= chg_nxt;
    gens_r <= gens_nxt;
    st_r <= st_nxt;
    ca_r <= ca_nxt;
    nc_r <= nc_nxt;
    op_r <= op_nxt;
    scan_r <= scan_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (c_r == CW'(MAX_WIDTH - 1) && r_r == RW'(MAX_HEIGHT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_valid && cfg_ready) state_nxt = ST_CLEAR;
        else if (in_valid && in_ready) begin
          if ((in_operation == OP_WRITE || in_operation == OP_READ) &&
              (EW'(in_col) >= ewf || EW'(in_row) >= ehf)) state_nxt = ST_RESP;
          else if (in_operation == OP_WRITE || in_operation == OP_READ)
            state_nxt = ST_PUT_RD;
          else if (in_operation == OP_RUN && in_generations != 16'd0) state_nxt = ST_COPY;
          else state_nxt = ST_RESP;
        end
      end
      ST_PUT_RD: state_nxt = ST_PUT_WB;
      ST_PUT_WB: begin
        if (op_r == OP_READ) state_nxt = ST_RESP;
        else if (rdata[0] == live_r) begin
          if (!scan_r) state_nxt = ST_RESP;
          else state_nxt = scan_done ? ST_GEN_END : ST_SCAN_RD;
        end else state_nxt = ST_NB_RD;
      end
      ST_NB_RD: state_nxt = ST_NB_WB;
      ST_NB_WB: begin
        if (nb_r == 4'd7) begin
          if (!scan_r) state_nxt = ST_RESP;
          else state_nxt = scan_done ? ST_GEN_END : ST_SCAN_RD;
        end else state_nxt = ST_NB_RD;
      end
      ST_COPY: begin
        if (last_c && last_r) state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (snap_rdata[0] ? (snap_rdata[4:1] != CNT_TWO && snap_rdata[4:1] != CNT_THREE)
                          : (snap_rdata[4:1] == CNT_THREE))
          state_nxt = ST_PUT_RD;
        else if (last_sc && last_sr) state_nxt = ST_GEN_END;
        else state_nxt = ST_SCAN_RD;
      end
      ST_GEN_END: begin
        if (chg_r && gens_r != 16'd0) state_nxt = ST_COPY;
        else state_nxt = ST_RESP;
      end
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    ctl = '0;
    addr = {r_r, c_r};
    wdata = '0;
    c_nxt = c_r;
    r_nxt = r_r;
    sc_nxt = sc_r;
    sr_nxt = sr_r;
    nb_nxt = nb_r;
    live_nxt = live_r;
    chg_nxt = chg_r;
    gens_nxt = gens_r;
    gen_nxt = gen_r;
    st_nxt = st_r;
    ca_nxt = ca_r;
    nc_nxt = nc_r;
    op_nxt = op_r;
    scan_nxt = scan_r;
    outv_nxt = outv_r && !out_ready;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.wr = 1'b1;
        if (c_r == CW'(MAX_WIDTH - 1)) begin
          c_nxt = '0;
          r_nxt = (r_r == RW'(MAX_HEIGHT - 1)) ? '0 : r_r + RW'(1);
        end else c_nxt = c_r + CW'(1);
      end
      ST_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          c_nxt = '0;
          r_nxt = '0;
        end else if (in_valid && in_ready) begin
          op_nxt = in_operation;
          c_nxt = CW'(in_col);
          r_nxt = RW'(in_row);
          live_nxt = in_alive;
          gens_nxt = in_generations;
          scan_nxt = 1'b0;
          st_nxt = (in_operation == OP_WRITE || in_operation == OP_READ) &&
                   (EW'(in_col) >= ewf || EW'(in_row) >= ehf);
          ca_nxt = 1'b0;
          nc_nxt = '0;
          nb_nxt = '0;
          if (in_operation == OP_RUN && in_generations != 16'd0) begin
            c_nxt = '0;
            r_nxt = '0;
          end
        end
      end
      ST_PUT_RD: begin
        ctl.rd = 1'b1;
      end
      ST_PUT_WB: begin
        if (op_r == OP_READ && !scan_r) begin
          ca_nxt = rdata[0];
          nc_nxt = rdata[4:1];
        end
        if (op_r != OP_READ && rdata[0] != live_r) begin
          ctl.wr = 1'b1;
          wdata = {rdata[4:1], live_r};
          chg_nxt = 1'b1;
        end
        nb_nxt = '0;
      end
      ST_NB_RD: begin
        addr = {tr, tc};
        ctl.rd = 1'b1;
      end
      ST_NB_WB: begin
        addr = {tr, tc};
        ctl.wr = 1'b1;
        if (live_r) wdata = {(cnt < CNT_MAX) ? cnt + 4'd1 : cnt, rdata[0]};
        else wdata = {(cnt != 4'd0) ? cnt - 4'd1 : cnt, rdata[0]};
        nb_nxt = nb_r + 4'd1;
      end
      ST_COPY: begin
        ctl.rd = 1'b1;
        if (last_c) begin
          c_nxt = '0;
          r_nxt = last_r ? '0 : r_r + RW'(1);
        end else c_nxt = c_r + CW'(1);
        if (last_c && last_r) begin
          gen_nxt = gen_r + 32'd1;
          gens_nxt = gens_r - 16'd1;
          chg_nxt = 1'b0;
          sc_nxt = '0;
          sr_nxt = '0;
          scan_nxt = 1'b1;
          op_nxt = OP_WRITE;
        end
      end
      ST_SCAN_RD: begin
        ctl.snap_rd = 1'b1;
      end
      ST_SCAN_EV: begin
        c_nxt = sc_r;
        r_nxt = sr_r;
        live_nxt = !snap_rdata[0];
        if (last_sc) begin
          sc_nxt = '0;
          sr_nxt = last_sr ? '0 : sr_r + RW'(1);
        end else sc_nxt = sc_r + CW'(1);
      end
      ST_GEN_END: begin
        if (!chg_r) gen_nxt = gen_r + {16'd0, gens_r};
        c_nxt = '0;
        r_nxt = '0;
        scan_nxt = 1'b0;
      end
      ST_RESP: begin
        outv_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Copy pipeline: the cell read in one cycle is written to the snapshot in the next.
  logic copy_wr_r;
  logic [AW-1:0] copy_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) copy_wr_r <= 1'b0;
    else copy_wr_r <= (state_r == ST_COPY);
    copy_addr_r <= {r_r, c_r};
  end

  // Snapshot writes follow the delayed copy strobe.
  mem_ctl_t ctl_m;
  always_comb begin
    ctl_m = ctl;
    ctl_m.snap_wr = copy_wr_r;
  end

  tla_store #(.AW(AW)) u_store (
    .clk(clk), .ctl(ctl_m), .addr(addr), .wdata(wdata),
    .snap_waddr(copy_addr_r), .snap_wdata(rdata),
    .snap_addr({sr_r, sc_r}), .rdata(rdata), .snap_rdata(snap_rdata)
  );

  assign out_valid = outv_r;
  assign out_status = st_r;
  assign out_cell_alive = ca_r;
  assign out_neighbour_count = nc_r;
  assign out_generation = gen_r;

  // Assertions on the sequencer.
  `TLA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, in_valid && in_ready, !outv_r,
    "request accepted while a result waits")
  `TLA_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == ST_IDLE,
    "ready outside idle")
  `TLA_ASSERT_NEXT(a_resp_valid, clk, rst_n, state_r == ST_RESP, out_valid,
    "result not raised after response state")
  `TLA_ASSERT_IMPL(a_nb_range, clk, rst_n, state_r == ST_NB_WB, nb_r <= 4'd7,
    "neighbour step out of range")
endmodule
`default_nettype wire

// File: hdl/tla_store.sv
// Cell memory and snapshot memory with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module tla_store
  import tla_pkg::*;
#(
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire mem_ctl_t      ctl,
  input  wire logic [AW-1:0] addr,
  input  wire logic [4:0]    wdata,
  input  wire logic [AW-1:0] snap_waddr,
  input  wire logic [4:0]    snap_wdata,
  input  wire logic [AW-1:0] snap_addr,
  output logic [4:0]         rdata,
  output logic [4:0]         snap_rdata
);
  logic [4:0] cells_mem [2**AW];
  logic [4:0] snap_mem  [2**AW];

  // Cell store: one port, read or write.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      cells_mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= cells_mem[addr];
    end
  end

  // Snapshot store: copy writes at the delayed copy address, scan reads at its own.
  always_ff @(posedge clk) begin
    if (ctl.snap_wr) begin
      snap_mem[snap_waddr] <= snap_wdata;
    end
    if (ctl.snap_rd) begin
      snap_rdata <= snap_mem[snap_addr];
    end
  end
endmodule
`default_nettype wire

// File: verif/life_grid_checker.sv
// Checker of the toroidal life automaton: predicts every result and compares it.
`timescale 1ns / 1ps
module life_grid_checker
  import tla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_col,
  input  logic [5:0]  in_row,
  input  logic        in_alive,
  input  logic [15:0] in_generations,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_status,
  input  logic        out_cell_alive,
  input  logic [3:0]  out_neighbour_count,
  input  logic [31:0] out_generation,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  localparam int GRID_SPAN = DEF_MAX_WIDTH;
  localparam int GRID_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  typedef struct packed {
    logic        status;
    logic        cell_alive;
    logic [3:0]  neighbour_count;
    logic [31:0] generation;
  } life_result_t;

  // Model copy of the grid: bit 0 live, bits 4..1 neighbour count.
  logic [4:0]  grid_mem [GRID_CELLS];
  logic [4:0]  grid_snap [GRID_CELLS];
  logic [31:0] gen_total;
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;
  life_result_t awaited_results [$];

  assign pending = awaited_results.size();

  function automatic int clamp_dim(logic [6:0] v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic int cols_used();
    return clamp_dim(width_reg, DEF_MAX_WIDTH);
  endfunction

  function automatic int rows_used();
    return clamp_dim(height_reg, DEF_MAX_HEIGHT);
  endfunction

  // Adds or removes one from each of the eight wrapped neighbour counts.
  function automatic void shift_neighbours(int c, int r, bit up);
    int w;
    int h;
    int cs [3];
    int rs [3];
    int idx;
    logic [3:0] cnt;
    w = cols_used();
    h = rows_used();
    cs[0] = (c == 0) ? w - 1 : c - 1;
    cs[1] = c;
    cs[2] = (c + 1 >= w) ? 0 : c + 1;
    rs[0] = (r == 0) ? h - 1 : r - 1;
    rs[1] = r;
    rs[2] = (r + 1 >= h) ? 0 : r + 1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i == 1 && j == 1) continue;
        idx = rs[i] * GRID_SPAN + cs[j];
        cnt = grid_mem[idx][4:1];
        if (up) begin
          if (cnt < CNT_MAX) cnt++;
        end else begin
          if (cnt > 0) cnt--;
        end
        grid_mem[idx] = {cnt, grid_mem[idx][0]};
      end
    end
  endfunction

  // Sets one live bit; returns 1 when it actually changed.
  function automatic bit set_cell(int c, int r, bit live);
    int idx;
    idx = r * GRID_SPAN + c;
    if (grid_mem[idx][0] == live) return 0;
    grid_mem[idx][0] = live;
    shift_neighbours(c, r, live);
    return 1;
  endfunction

  // One generation from a snapshot; returns 1 when any cell changed.
  function automatic bit step_generation();
    int w;
    int h;
    bit changed;
    logic [4:0] v;
    w = cols_used();
    h = rows_used();
    changed = 0;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) grid_snap[r * GRID_SPAN + c] = grid_mem[r * GRID_SPAN + c];
    gen_total++;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        v = grid_snap[r * GRID_SPAN + c];
        if (v == '0) continue;
        if (v[0]) begin
          if (v[4:1] != CNT_TWO && v[4:1] != CNT_THREE) changed |= set_cell(c, r, 1'b0);
        end else if (v[4:1] == CNT_THREE) begin
          changed |= set_cell(c, r, 1'b1);
        end
      end
    end
    return changed;
  endfunction

  function automatic life_result_t predict_request(logic [1:0] op, int c, int r, bit live,
                                                   int gens);
    life_result_t res;
    int left;
    bit unused;
    res = '0;
    if (op == OP_WRITE || op == OP_READ) begin
      if (c >= cols_used() || r >= rows_used()) begin
        res.status = 1'b1;
      end else if (op == OP_WRITE) begin
        unused = set_cell(c, r, live);
      end else begin
        res.cell_alive = grid_mem[r * GRID_SPAN + c][0];
        res.neighbour_count = grid_mem[r * GRID_SPAN + c][4:1];
      end
    end else if (op == OP_RUN) begin
      // A generation without change means the rest only advance the counter.
      left = gens;
      while (left > 0) begin
        left--;
        if (!step_generation()) begin
          gen_total += left;
          break;
        end
      end
    end
    res.generation = gen_total;
    return res;
  endfunction

  // Watch the three channels; results are compared in arrival order.
  always @(posedge clk) begin
    life_result_t want;
    life_result_t got;
    if (!rst_n) begin
      foreach (grid_mem[i]) grid_mem[i] = '0;
      gen_total = '0;
      width_reg = 7'd64;
      height_reg = 7'd64;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
        foreach (grid_mem[i]) grid_mem[i] = '0;
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(predict_request(in_operation, int'(in_col), int'(in_row),
                                                  in_alive, int'(in_generations)));
      end
      if (out_valid && out_ready) begin
        got = {out_status, out_cell_alive, out_neighbour_count, out_generation};
        if (awaited_results.size() == 0) begin
          $error("result with nothing expected: %p", got);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.cell_alive !== want.cell_alive) begin
            $error("cell_alive: expected %0d, got %0d", want.cell_alive, got.cell_alive);
            fail_count++;
          end
          if (got.neighbour_count !== want.neighbour_count) begin
            $error("neighbour_count: expected %0d, got %0d", want.neighbour_count,
                   got.neighbour_count);
            fail_count++;
          end
          if (got.generation !== want.generation) begin
            $error("generation: expected %0d, got %0d", want.generation, got.generation);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// File: verif/tb_toroidal_life_automaton_core.sv
// Testbench top of the toroidal life automaton: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_toroidal_life_automaton_core;
  import tla_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int IDLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 17;
  localparam int PHASES = 7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_WRITE;
  logic [5:0]  in_col = '0;
  logic [5:0]  in_row = '0;
  logic        in_alive = 1'b0;
  logic [15:0] in_generations = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic        out_cell_alive;
  logic [3:0]  out_neighbour_count;
  logic [31:0] out_generation;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_WIDTH;
  logic [6:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int ready_hold = 0;
  bit calm = 0;
  int cols_now = 64;
  int rows_now = 64;

  always #5 clk = ~clk;

  toroidal_life_automaton_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_col(in_col), .in_row(in_row), .in_alive(in_alive),
    .in_generations(in_generations),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_cell_alive(out_cell_alive), .out_neighbour_count(out_neighbour_count),
    .out_generation(out_generation),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  life_grid_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_col(in_col), .in_row(in_row), .in_alive(in_alive),
    .in_generations(in_generations),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_cell_alive(out_cell_alive), .out_neighbour_count(out_neighbour_count),
    .out_generation(out_generation),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Result side back-pressure: mostly ready, with short and a few long stalls.
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < 75) begin
      out_ready <= 1'b1;
    end else begin
      ready_hold <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
      out_ready <= 1'b0;
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int clamp_dim(int v);
    if (v < 3) return 3;
    if (v > 64) return 64;
    return v;
  endfunction

  task automatic pause_random();
    int n;
    if (calm) n = 0;
    else if ($urandom_range(99) < 70) n = 0;
    else if ($urandom_range(99) < 85) n = $urandom_range(3, 1);
    else n = $urandom_range(40, 10);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one request and hold it until accepted; valid stays up afterwards.
  task automatic send_request(logic [1:0] op, int c, int r, bit live, int gens);
    pause_random();
    in_valid <= 1'b1;
    in_operation <= op;
    in_col <= c[5:0];
    in_row <= r[5:0];
    in_alive <= live;
    in_generations <= gens[15:0];
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
  endtask

  // Drain all results, then write one geometry register.
  task automatic write_geometry(logic idx, logic [6:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH) cols_now = clamp_dim(int'(value));
    else rows_now = clamp_dim(int'(value));
  endtask

  task automatic random_request();
    int pick;
    int c;
    int r;
    pick = $urandom_range(99);
    c = $urandom_range(cols_now - 1);
    r = $urandom_range(rows_now - 1);
    if (pick < 45) begin
      send_request(OP_WRITE, c, r, $urandom_range(99) < 70, $urandom_range(65535));
    end else if (pick < 70) begin
      send_request(OP_READ, c, r, $urandom_range(1), $urandom_range(65535));
    end else if (pick < 82) begin
      // Large grids sweep slowly, so they get only a generation or so.
      send_request(OP_RUN, $urandom_range(63), $urandom_range(63), $urandom_range(1),
                   (cols_now * rows_now > 256) ? $urandom_range(1) : $urandom_range(25));
    end else if (pick < 92) begin
      c = (cols_now < 64 && $urandom_range(1)) ? $urandom_range(63, cols_now) : c;
      r = (rows_now < 64 && $urandom_range(1)) ? $urandom_range(63, rows_now) : r;
      send_request($urandom_range(1) ? OP_WRITE : OP_READ, c, r, $urandom_range(1), 0);
    end else begin
      send_request(OP_NONE, $urandom_range(63), $urandom_range(63), $urandom_range(1),
                   $urandom_range(65535));
    end
  endtask

  initial begin
    int w;
    int h;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Default 64 by 64 grid: corners that wrap onto each other.
    send_request(OP_WRITE, 0, 0, 1, 0);
    send_request(OP_WRITE, 63, 63, 1, 65535);
    send_request(OP_READ, 63, 0, 0, 0);
    send_request(OP_READ, 0, 0, 0, 0);
    send_request(OP_WRITE, 0, 0, 1, 0);
    send_request(OP_NONE, 63, 63, 1, 65535);
    send_request(OP_RUN, 0, 0, 0, 0);
    send_request(OP_RUN, 0, 0, 0, 1);
    send_request(OP_RUN, 63, 63, 1, 65535);
    send_request(OP_READ, 0, 0, 0, 0);
    send_request(OP_WRITE, 63, 63, 0, 0);

    // Smallest grid: a row of three, coordinates outside, then a run.
    write_geometry(CFG_WIDTH, 7'd3);
    write_geometry(CFG_HEIGHT, 7'd3);
    send_request(OP_WRITE, 1, 1, 1, 0);
    send_request(OP_WRITE, 0, 1, 1, 0);
    send_request(OP_WRITE, 2, 1, 1, 0);
    send_request(OP_READ, 0, 0, 0, 0);
    send_request(OP_WRITE, 5, 0, 1, 0);
    send_request(OP_READ, 0, 3, 0, 0);
    send_request(OP_RUN, 0, 0, 0, 2);
    send_request(OP_READ, 1, 1, 0, 0);

    // Register values outside the legal range are clamped.
    write_geometry(CFG_WIDTH, 7'd0);
    write_geometry(CFG_HEIGHT, 7'd127);
    send_request(OP_WRITE, 2, 63, 1, 0);
    send_request(OP_READ, 3, 0, 0, 0);
    send_request(OP_READ, 0, 63, 0, 0);
    send_request(OP_RUN, 0, 0, 0, 3);

    // Random phases, mostly on small grids, some free of idling.
    for (int p = 0; p < PHASES; p++) begin
      if ($urandom_range(6) == 0) w = $urandom_range(127, 40);
      else if ($urandom_range(9) == 0) w = $urandom_range(2);
      else w = $urandom_range(12, 3);
      if ($urandom_range(6) == 0) h = $urandom_range(127, 40);
      else if ($urandom_range(9) == 0) h = $urandom_range(2);
      else h = $urandom_range(12, 3);
      write_geometry(CFG_WIDTH, w[6:0]);
      write_geometry(CFG_HEIGHT, h[6:0]);
      calm = ($urandom_range(3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) random_request();
    end
    calm = 0;

    // Drain and let the block settle before the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
